>>> hw/rtl/bucketed_hash_set_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bucketed hash set unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_SET_UNIT_ASSERT_SVH
`define BUCKETED_HASH_SET_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// Types and constants shared by the bucketed hash set unit.
// ----------------------------------------------------------------------------
package bhs_pkg;

    localparam int KEY_W       = 31;
    localparam int TS_W        = 7;
    localparam int BUCKET_OUT_W = 6;
    localparam int COUNT_OUT_W = 9;
    localparam int BIT_CNT_W   = 5;

    localparam logic [TS_W-1:0]      TS_RESET      = 7'd64;
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_START = 5'd30;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_FOUND    = 3'd4,
        ST_MISSING  = 3'd5
    } bhs_status_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
    } bhs_req_t;

    typedef struct packed {
        bhs_status_t              status;
        logic [BUCKET_OUT_W-1:0]  bucket;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } bhs_rsp_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK
    } bhs_state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic div_step;
        logic commit;
    } bhs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic rsp_busy;
    } bhs_stat_t;

endpackage

>>> hw/rtl/bucketed_hash_set_unit.sv
// ----------------------------------------------------------------------------
// Bucketed hash set unit: insert, remove and search of keys in fixed-size buckets.
// An accepted transaction runs the serial modulo hash, then one bucket read and
// one compare and write, which also registers its result. No new transaction is
// taken before the last one commits; a commit waits while the result side stalls.
// After reset the valid bits are cleared one bucket a cycle until all are clear.
// ----------------------------------------------------------------------------
module bucketed_hash_set_unit
    import bhs_pkg::*;
#(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [TS_W-1:0] cfg_wr_data,
    input  logic            req_valid,
    output logic            req_stall,
    input  bhs_req_t        req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bhs_rsp_t        rsp
);

    bhs_cmd_t  cmd;
    bhs_stat_t stat;

    bhs_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bhs_datapath #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp_stall   (rsp_stall),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

>>> hw/rtl/bhs_datapath.sv
// ----------------------------------------------------------------------------
// bhs_datapath
// Bit-serial modulo hash, bucket memories, slot compare and result register.
// ----------------------------------------------------------------------------
module bhs_datapath
    import bhs_pkg::*;
#(
    parameter int NUM_BUCKETS  = 64,
    parameter int BUCKET_DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [TS_W-1:0] cfg_wr_data,
    input  bhs_req_t        req,
    input  logic            rsp_stall,
    output logic            rsp_valid,
    output bhs_rsp_t        rsp,
    input  bhs_cmd_t        cmd,
    output bhs_stat_t       stat
);

    localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ROW_W = BUCKET_DEPTH * KEY_W;

    logic [TS_W-1:0]         table_size_reg;
    logic [1:0]              func_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg;
    logic [TS_W-1:0]         rem_reg;
    logic [TS_W-1:0]         rem_next;
    logic [BKT_W-1:0]        clr_addr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    rsp_valid_reg;
    bhs_rsp_t                rsp_reg;
    logic [BUCKET_DEPTH-1:0] rd_valid_reg;
    logic [ROW_W-1:0]        rd_key_reg;

    logic [BUCKET_DEPTH-1:0] valid_mem [NUM_BUCKETS];
    logic [ROW_W-1:0]        key_mem   [NUM_BUCKETS];

    logic [TS_W-1:0]         divisor;
    logic [TS_W:0]           shifted;
    logic [TS_W:0]           diff;
    logic [BKT_W-1:0]        bucket_idx;
    logic [BKT_W-1:0]        wr_addr;
    logic [BUCKET_DEPTH-1:0] hit_vec;
    logic [BUCKET_DEPTH-1:0] hit_oh;
    logic [BUCKET_DEPTH-1:0] free_vec;
    logic [BUCKET_DEPTH-1:0] free_oh;
    logic                    do_insert;
    logic [BUCKET_DEPTH-1:0] valid_row_next;
    logic [ROW_W-1:0]        key_row_next;
    bhs_status_t             status;

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            divisor = 7'd1;
        end
        else if (32'(table_size_reg) > NUM_BUCKETS)
        begin
            divisor = TS_W'(NUM_BUCKETS);
        end
        else
        begin
            divisor = table_size_reg;
        end
    end

    assign shifted    = {rem_reg, key_reg[bit_cnt_reg]};
    assign diff       = shifted - {1'b0, divisor};
    assign rem_next   = (shifted >= {1'b0, divisor}) ? diff[TS_W-1:0] : shifted[TS_W-1:0];
    assign bucket_idx = BKT_W'(rem_reg);
    assign wr_addr    = cmd.clear_wr ? clr_addr_reg : bucket_idx;

    always_comb
    begin
        for (int i = 0; i < BUCKET_DEPTH; i++)
        begin
            hit_vec[i] = rd_valid_reg[i] && (rd_key_reg[i*KEY_W +: KEY_W] == key_reg);
        end
    end

    assign free_vec = ~rd_valid_reg;
    assign hit_oh   = hit_vec & (~hit_vec + BUCKET_DEPTH'(1));
    assign free_oh  = free_vec & (~free_vec + BUCKET_DEPTH'(1));

    always_comb
    begin
        status         = ST_MISSING;
        do_insert      = 1'b0;
        valid_row_next = rd_valid_reg;
        count_next     = count_reg;
        unique case (func_reg)
            FUNC_INSERT:
            begin
                if (|hit_vec)
                begin
                    status = ST_PRESENT;
                end
                else if (|free_vec)
                begin
                    status         = ST_INSERTED;
                    do_insert      = 1'b1;
                    valid_row_next = rd_valid_reg | free_oh;
                    count_next     = count_reg + CNT_W'(1);
                end
                else
                begin
                    status = ST_FULL;
                end
            end
            FUNC_REMOVE:
            begin
                if (|hit_vec)
                begin
                    status         = ST_REMOVED;
                    valid_row_next = rd_valid_reg & ~hit_oh;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status = (|hit_vec) ? ST_FOUND : ST_MISSING;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < BUCKET_DEPTH; i++)
        begin
            key_row_next[i*KEY_W +: KEY_W] = (do_insert && free_oh[i]) ?
                key_reg : rd_key_reg[i*KEY_W +: KEY_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr || cmd.commit)
        begin
            valid_mem[wr_addr] <= cmd.clear_wr ? '0 : valid_row_next;
        end
        if (cmd.commit)
        begin
            key_mem[bucket_idx] <= key_row_next;
        end
        rd_valid_reg <= valid_mem[bucket_idx];
        rd_key_reg   <= key_mem[bucket_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= req.func;
            key_reg     <= req.key;
            rem_reg     <= '0;
            bit_cnt_reg <= BIT_CNT_START;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
        end
        if (cmd.commit)
        begin
            rsp_reg.status      <= status;
            rsp_reg.bucket      <= BUCKET_OUT_W'(rem_reg);
            rsp_reg.entry_count <= COUNT_OUT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TS_RESET;
            clr_addr_reg   <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + BKT_W'(1);
            end
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clear_last = (clr_addr_reg == BKT_W'(NUM_BUCKETS - 1));
    assign stat.div_last   = (bit_cnt_reg == '0);
    assign stat.rsp_busy   = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> hw/rtl/bhs_controller.sv
// ----------------------------------------------------------------------------
// bhs_controller
// Sequences the clearing pass, the serial hash, the bucket access and commit.
// ----------------------------------------------------------------------------
module bhs_controller
    import bhs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  bhs_stat_t stat,
    output bhs_cmd_t  cmd
);

    bhs_state_t state_reg;
    bhs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.rsp_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            S_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_READ:
            begin
                cmd = '0;
            end
            S_CHECK:
            begin
                cmd.commit = !stat.rsp_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/bhs_checker.sv
// ----------------------------------------------------------------------------
// bhs_checker
// Port-level checks of the bucketed hash set unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "bucketed_hash_set_unit_assert.svh"

module bhs_checker
    import bhs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input bhs_rsp_t rsp
);

    `BHS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
    `BHS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request accepted while busy")
    `BHS_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), $past(req_stall), "result without pending work")
    `BHS_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !$rose(rsp_valid), "result too early")

endmodule

bind bucketed_hash_set_unit bhs_checker u_bhs_checker (.*);
